[hdl/servo_status_frame_receiver_core_macros.svh]
// assertion helpers for the servo status frame receiver
`ifndef SERVO_STATUS_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERVO_STATUS_FRAME_RECEIVER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SSFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// non-overlapping implication checked outside reset
`define SSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/ssfr_pkg.sv]
`default_nettype none
package ssfr_pkg;
	localparam int WINDOW_BYTES_DEF = 64;
	localparam logic [7:0] SYNC_A = 8'hFF;
	localparam logic [7:0] SYNC_B = 8'hF5;
	localparam logic [7:0] HEADER_RESET = 8'hFF;
	localparam int MIN_WINDOW = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_SUM,
		ST_CK,
		ST_TBL,
		ST_EMIT,
		ST_FAIL
	} scan_state_t;

	// request from the scanner to the status table
	typedef struct packed {
		logic       wr;
		logic [7:0] id;
		logic [7:0] status;
	} tbl_wr_t;
endpackage
`default_nettype wire

[hdl/servo_status_frame_receiver_core.sv]
`default_nettype none
// Servo status frame receiver. Each start transfer stores one byte into the
// receive window (up to WINDOW_BYTES; extra bytes are dropped). A transfer
// with end_of_window set starts a scan of the window: each offset is read
// through the single read port of the window memory, header bytes first and
// then every byte from status to checksum, moving on to the next offset if
// the header or checksum fails; a passing frame writes the status table, and
// results then come one per cycle with a strobe; the receiver cannot stall
// them. busy is high during the scan and after reset while the 256-entry
// per-id status table is cleared. Non-final bytes leave the receiver idle.
module servo_status_frame_receiver_core #(
	parameter int WINDOW_BYTES = ssfr_pkg::WINDOW_BYTES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,
	input  wire [7:0]  rx_byte,
	input  wire        end_of_window,
	input  wire [7:0]  wanted_id,
	input  wire [7:0]  max_params,
	output logic       strobe,
	output logic       found,
	output logic [7:0] status_code,
	output logic [5:0] copy_count,
	output logic [7:0] param_byte,
	output logic       byte_valid,
	output logic       last_result
);
	import ssfr_pkg::*;

	logic [7:0] header_q;
	tbl_wr_t    tbl_wr;
	logic       tbl_busy;

	// header register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) header_q <= HEADER_RESET;
		else if (cfg_we) header_q <= cfg_wdata;
	end

	ssfr_scanner #(.WINDOW_BYTES(WINDOW_BYTES)) u_scan (
		.clk, .arst_n, .start, .hold(tbl_busy), .rx_byte, .end_of_window,
		.wanted_id, .max_params, .header_first(header_q), .busy, .tbl_wr,
		.strobe, .found, .status_code, .copy_count, .param_byte, .byte_valid,
		.last_result
	);

	ssfr_status_table u_tbl (.clk, .arst_n, .wr_req(tbl_wr), .busy(tbl_busy));
endmodule
`default_nettype wire

[hdl/ssfr_status_table.sv]
`default_nettype none
module ssfr_status_table (
	input  wire             clk,
	input  wire             arst_n,
	input  wire ssfr_pkg::tbl_wr_t wr_req,
	output logic            busy
);
	import ssfr_pkg::*;

	logic [7:0] mem [256];
	logic [7:0] clr_addr_q;
	logic       clearing_q;

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 8'd1;
			if (clr_addr_q == 8'hFF) clearing_q <= 1'b0;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (clearing_q) mem[clr_addr_q] <= '0;
		else if (wr_req.wr) mem[wr_req.id] <= wr_req.status;
	end

	assign busy = clearing_q;
endmodule
`default_nettype wire

[hdl/ssfr_scanner.sv]
`default_nettype none
`include "servo_status_frame_receiver_core_macros.svh"
module ssfr_scanner #(
	parameter int WINDOW_BYTES = ssfr_pkg::WINDOW_BYTES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire        hold,
	input  wire [7:0]  rx_byte,
	input  wire        end_of_window,
	input  wire [7:0]  wanted_id,
	input  wire [7:0]  max_params,
	input  wire [7:0]  header_first,
	output logic       busy,
	output ssfr_pkg::tbl_wr_t tbl_wr,
	output logic       strobe,
	output logic       found,
	output logic [7:0] status_code,
	output logic [5:0] copy_count,
	output logic [7:0] param_byte,
	output logic       byte_valid,
	output logic       last_result
);
	import ssfr_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int CW = $clog2(WINDOW_BYTES + 1);
	localparam int PW = CW + 1;
	localparam int XW = PW + 2;

	logic [7:0] mem [WINDOW_BYTES];
	logic [7:0] rd_s1;
	logic [AW-1:0] rd_addr;
	logic       wr_en;

	scan_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [PW-1:0] off_q, off_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic [PW-1:0] ckpos_q, ckpos_d;
	logic [7:0] want_q, want_d, maxp_q, maxp_d;
	logic [7:0] len_q, len_d, st_q, st_d, sum_q, sum_d;
	logic [7:0] copy_q, copy_d, emit_q, emit_d;
	logic [PW:0] last_start;
	logic [XW-1:0] ck_end;

	// window memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[cnt_q[AW-1:0]] <= rx_byte;
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d; ptr_q <= ptr_d; ckpos_q <= ckpos_d;
		want_q <= want_d; maxp_q <= maxp_d; len_q <= len_d;
		st_q <= st_d; sum_q <= sum_d; copy_q <= copy_d; emit_q <= emit_d;
	end

	assign last_start = {1'b0, off_q} + (PW+1)'(6);
	assign ck_end = {2'b0, off_q} + XW'(3) + XW'(rd_s1);

	// scan sequencer: each read is issued in the state ahead of the one that uses its data
	always_comb begin
		state_d = state_q; cnt_d = cnt_q; off_d = off_q; ptr_d = ptr_q;
		ckpos_d = ckpos_q; want_d = want_q; maxp_d = maxp_q; len_d = len_q;
		st_d = st_q; sum_d = sum_q; copy_d = copy_q; emit_d = emit_q;
		wr_en = 1'b0; rd_addr = ptr_q[AW-1:0];
		tbl_wr = '0; strobe = 1'b0; found = 1'b0; status_code = '0;
		copy_count = '0; param_byte = '0; byte_valid = 1'b0; last_result = 1'b0;
		busy = (state_q != ST_IDLE) || hold;
		case (state_q)
			ST_IDLE: begin
				if (start && !hold) begin
					if (cnt_q < CW'(WINDOW_BYTES)) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end
					if (end_of_window) begin
						want_d = wanted_id;
						maxp_d = max_params;
						off_d = '0;
						ptr_d = '0;
						rd_addr = '0;
						if (cnt_d < CW'(MIN_WINDOW)) state_d = ST_FAIL;
						else state_d = ST_H0;
					end
				end
			end
			ST_H0: begin
				// header byte at the offset; next read offset+1
				if (rd_s1 != header_first) begin
					sum_d = 8'd1; state_d = ST_CK;
				end else begin
					rd_addr = AW'(off_q + PW'(1)); state_d = ST_H1;
				end
			end
			ST_H1: begin
				if (rd_s1 != SYNC_A && rd_s1 != SYNC_B) begin
					sum_d = 8'd1; state_d = ST_CK;
				end else begin
					rd_addr = AW'(off_q + PW'(2)); state_d = ST_H2;
				end
			end
			ST_H2: begin
				if (rd_s1 != want_q) begin
					sum_d = 8'd1; state_d = ST_CK;
				end else begin
					rd_addr = AW'(off_q + PW'(3)); state_d = ST_H3;
				end
			end
			ST_H3: begin
				len_d = rd_s1;
				ckpos_d = PW'(ck_end);
				if (rd_s1 < 8'd2 || ck_end >= XW'(cnt_q)) begin
					sum_d = 8'd1; state_d = ST_CK;
				end else begin
					sum_d = want_q + rd_s1;
					ptr_d = off_q + PW'(4);
					rd_addr = AW'(off_q + PW'(4));
					state_d = ST_SUM;
					emit_d = 8'd0;
				end
			end
			ST_SUM: begin
				// status then params then checksum stream in order
				if (ptr_q == ckpos_q) begin
					if (rd_s1 == ~sum_q) state_d = ST_TBL;
					else begin
						sum_d = 8'd1; state_d = ST_CK;
					end
				end else begin
					if (emit_q == 8'd0) st_d = rd_s1;
					sum_d = sum_q + rd_s1;
					emit_d = 8'd1;
					ptr_d = ptr_q + PW'(1);
					rd_addr = AW'(ptr_q + PW'(1));
				end
			end
			ST_CK: begin
				// advance to next offset or give up
				if ({1'b0, last_start} >= (PW+2)'(cnt_q)) state_d = ST_FAIL;
				else begin
					off_d = off_q + PW'(1);
					rd_addr = AW'(off_q + PW'(1));
					state_d = ST_H0;
				end
			end
			ST_TBL: begin
				tbl_wr.wr = 1'b1; tbl_wr.id = want_q; tbl_wr.status = st_q;
				copy_d = ((len_q - 8'd2) < maxp_q) ? (len_q - 8'd2) : maxp_q;
				emit_d = 8'd0;
				ptr_d = off_q + PW'(5);
				rd_addr = AW'(off_q + PW'(5));
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				strobe = 1'b1; found = 1'b1; status_code = st_q;
				copy_count = copy_q[5:0];
				if (copy_q == 8'd0) begin
					last_result = 1'b1; state_d = ST_IDLE; cnt_d = '0;
				end else begin
					param_byte = rd_s1; byte_valid = 1'b1;
					emit_d = emit_q + 8'd1;
					ptr_d = ptr_q + PW'(1);
					rd_addr = AW'(ptr_q + PW'(1));
					if (emit_q + 8'd1 == copy_q) begin
						last_result = 1'b1; state_d = ST_IDLE; cnt_d = '0;
					end
				end
			end
			ST_FAIL: begin
				strobe = 1'b1; last_result = 1'b1;
				state_d = ST_IDLE; cnt_d = '0;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SSFR_ASSERT_IMP(a_fail_clean, clk, arst_n, strobe && !found, status_code == 8'd0 && !byte_valid)
	`SSFR_ASSERT_NEXT(a_last_idle, clk, arst_n, strobe && last_result, state_q == ST_IDLE && cnt_q == '0)
	`SSFR_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(WINDOW_BYTES))
endmodule
`default_nettype wire
